@@ hw/rtl/wil_pkg.sv @@
package wil_pkg;

	// Default list capacity and fixed field widths.
	localparam int CAPACITY_DEF = 64;
	localparam int POS_W        = 16;
	localparam int DATA_W       = 32;
	localparam int COUNT_OUT_W  = 7;

	// Value returned by a get on an empty list.
	localparam logic signed [DATA_W-1:0] READ_EMPTY = -32'sd1;

	// Request operation codes.
	typedef enum logic [1:0] {
		KIND_GET    = 2'd0,
		KIND_SET    = 2'd1,
		KIND_APPEND = 2'd2,
		KIND_REMOVE = 2'd3
	} kind_t;

	// Request payload.
	typedef struct packed {
		kind_t                     kind;
		logic [POS_W-1:0]          position;
		logic signed [DATA_W-1:0]  new_value;
	} req_t;

	// Result payload.
	typedef struct packed {
		logic signed [DATA_W-1:0]  read_value;
		logic [COUNT_OUT_W-1:0]    entry_count;
		logic                      is_empty;
		logic                      rejected;
	} res_t;

	// Command broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		CELL_NOP,
		CELL_WRITE,
		CELL_REMOVE,
		CELL_CAPTURE,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic signed [DATA_W-1:0]  value;
	} cell_cmd_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_APPLY,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

@@ hw/rtl/wil_mod.sv @@
module wil_mod #(
	parameter int CW = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [wil_pkg::POS_W-1:0]  dividend,
	input  logic [CW-1:0]              divisor,
	output logic                       done,
	output logic [CW-1:0]              remainder
);

	localparam int STEP_W = $clog2(wil_pkg::POS_W);

	logic                       busy_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic [wil_pkg::POS_W-1:0]  quo_q;
	logic [CW-1:0]              rem_q;
	logic [CW:0]                trial;
	logic [CW:0]                rem_next;

	// One restoring step: bring down the next dividend bit and subtract if it fits.
	always_comb begin
		trial = {rem_q, quo_q[wil_pkg::POS_W-1]};
		if (trial >= {1'b0, divisor}) begin
			rem_next = trial - {1'b0, divisor};
		end else begin
			rem_next = trial;
		end
	end

	// Control of the iteration, one dividend bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					step_q <= STEP_W'(wil_pkg::POS_W - 1);
				end
			end else begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and the shifting dividend.
	always_ff @(posedge clk) begin
		if (!busy_q) begin
			if (start) begin
				quo_q <= dividend;
				rem_q <= '0;
			end
		end else begin
			quo_q <= {quo_q[wil_pkg::POS_W-2:0], 1'b0};
			rem_q <= rem_next[CW-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

@@ hw/rtl/wil_cell.sv @@
module wil_cell #(
	parameter int IDX = 0,
	parameter int IW  = 6,
	parameter int CW  = 7
) (
	input  logic                               clk,
	input  wil_pkg::cell_cmd_t                 cmd,
	input  logic [IW-1:0]                      slot,
	input  logic [CW-1:0]                      count,
	input  logic signed [wil_pkg::DATA_W-1:0]  right_entry,
	input  logic signed [wil_pkg::DATA_W-1:0]  right_rd,
	output logic signed [wil_pkg::DATA_W-1:0]  entry,
	output logic signed [wil_pkg::DATA_W-1:0]  rd
);

	localparam logic [IW-1:0] IDX_L  = IW'(IDX);
	localparam logic [CW-1:0] NEXT_L = CW'(IDX + 1);

	logic signed [wil_pkg::DATA_W-1:0] entry_q;
	logic signed [wil_pkg::DATA_W-1:0] rd_q;
	logic                              hit;

	assign hit = (slot == IDX_L);

	// The cell holds one entry and one word of the read chain towards cell zero.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			wil_pkg::CELL_NOP: begin
			end
			wil_pkg::CELL_WRITE: begin
				if (hit) begin
					entry_q <= cmd.value;
				end
			end
			wil_pkg::CELL_REMOVE: begin
				// Cells from the removed place onwards take their right neighbour's entry.
				if ((IDX_L >= slot) && (NEXT_L < count)) begin
					entry_q <= right_entry;
				end
			end
			wil_pkg::CELL_CAPTURE: begin
				if (hit) begin
					rd_q <= entry_q;
				end
			end
			wil_pkg::CELL_SHIFT: begin
				rd_q <= right_rd;
			end
		endcase
	end

	assign entry = entry_q;
	assign rd    = rd_q;

endmodule

@@ hw/rtl/wrapping_indexed_list.sv @@
// A request on an empty list skips the wrap and goes straight to the result; an append skips the wrap and is applied.
// A set or remove first waits for the 16-step remainder unit that wraps the position.
// A get then walks its entry down the cell chain, one cell per wrapped index.
// Only one request is taken at a time; the next is taken once the result is registered.
// Reset clears the sequencer, the count and the result valid; cell entries stay undefined.
module wrapping_indexed_list #(
	parameter int CAPACITY = wil_pkg::CAPACITY_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  wil_pkg::req_t  req,
	output logic           res_valid,
	input  logic           res_stall,
	output wil_pkg::res_t  res
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] FULL_L = CW'(CAPACITY);

	wil_pkg::state_t   state_q, state_d;
	wil_pkg::kind_t    kind_q;
	logic signed [wil_pkg::DATA_W-1:0] val_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     slot_q;
	logic [IW-1:0]     walk_q;
	logic              miss_q;
	logic              rej_q;
	logic              res_valid_q;
	wil_pkg::res_t     res_q;

	wil_pkg::cell_cmd_t cmd;
	logic [IW-1:0]      cell_slot;
	logic               div_start;
	logic               div_done;
	logic [CW-1:0]      div_rem;
	logic               accept;
	logic               res_load;
	logic signed [wil_pkg::DATA_W-1:0] entry_w [CAPACITY];
	logic signed [wil_pkg::DATA_W-1:0] rd_w    [CAPACITY];

	assign req_stall = (state_q != wil_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign res_load  = (state_q == wil_pkg::ST_DONE) && (!res_valid_q || !res_stall);

	// Remainder unit that wraps the position by the live count.
	wil_mod #(
		.CW(CW)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (req.position),
		.divisor   (count_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	// The chain of cells, each fed by its right neighbour; the last is fed zeros.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [wil_pkg::DATA_W-1:0] right_entry;
		logic signed [wil_pkg::DATA_W-1:0] right_rd;

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = '0;
			assign right_rd    = '0;
		end else begin : g_mid
			assign right_entry = entry_w[i+1];
			assign right_rd    = rd_w[i+1];
		end

		wil_cell #(
			.IDX(i),
			.IW (IW),
			.CW (CW)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.slot        (cell_slot),
			.count       (count_q),
			.right_entry (right_entry),
			.right_rd    (right_rd),
			.entry       (entry_w[i]),
			.rd          (rd_w[i])
		);
	end

	// Sequencer next state and the command to the cells.
	always_comb begin
		state_d   = state_q;
		cmd.op    = wil_pkg::CELL_NOP;
		cmd.value = val_q;
		cell_slot = slot_q;
		div_start = 1'b0;
		unique case (state_q)
			wil_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.kind == wil_pkg::KIND_APPEND) begin
						state_d = wil_pkg::ST_APPLY;
					end else if (count_q == '0) begin
						state_d = wil_pkg::ST_DONE;
					end else begin
						div_start = 1'b1;
						state_d   = wil_pkg::ST_DIV;
					end
				end
			end
			wil_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = wil_pkg::ST_APPLY;
				end
			end
			wil_pkg::ST_APPLY: begin
				state_d = wil_pkg::ST_DONE;
				unique case (kind_q)
					wil_pkg::KIND_GET: begin
						cmd.op = wil_pkg::CELL_CAPTURE;
						if (slot_q != '0) begin
							state_d = wil_pkg::ST_WALK;
						end
					end
					wil_pkg::KIND_SET: begin
						cmd.op = wil_pkg::CELL_WRITE;
					end
					wil_pkg::KIND_APPEND: begin
						cell_slot = count_q[IW-1:0];
						if (!rej_q) begin
							cmd.op = wil_pkg::CELL_WRITE;
						end
					end
					wil_pkg::KIND_REMOVE: begin
						cmd.op = wil_pkg::CELL_REMOVE;
					end
				endcase
			end
			wil_pkg::ST_WALK: begin
				cmd.op = wil_pkg::CELL_SHIFT;
				if (walk_q == IW'(1)) begin
					state_d = wil_pkg::ST_DONE;
				end
			end
			wil_pkg::ST_DONE: begin
				if (!res_valid_q || !res_stall) begin
					state_d = wil_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// State, count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wil_pkg::ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == wil_pkg::ST_APPLY) begin
				if ((kind_q == wil_pkg::KIND_APPEND) && !rej_q) begin
					count_q <= count_q + 1'b1;
				end else if (kind_q == wil_pkg::KIND_REMOVE) begin
					count_q <= count_q - 1'b1;
				end
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Request fields, wrapped index and read walk counter.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			val_q  <= req.new_value;
			miss_q <= (count_q == '0);
			rej_q  <= (req.kind == wil_pkg::KIND_APPEND) && (count_q == FULL_L);
		end
		if (div_done) begin
			slot_q <= div_rem[IW-1:0];
		end
		if (state_q == wil_pkg::ST_APPLY) begin
			walk_q <= slot_q;
		end else if (state_q == wil_pkg::ST_WALK) begin
			walk_q <= walk_q - 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (res_load) begin
			if (kind_q == wil_pkg::KIND_GET) begin
				res_q.read_value <= miss_q ? wil_pkg::READ_EMPTY : rd_w[0];
			end else begin
				res_q.read_value <= '0;
			end
			res_q.entry_count <= wil_pkg::COUNT_OUT_W'(count_q);
			res_q.is_empty    <= (count_q == '0);
			res_q.rejected    <= rej_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// The count never passes the capacity.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_L)
		else $error("entry count above capacity");

	// The remainder unit finishes only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == wil_pkg::ST_DIV))
		else $error("remainder ready outside the wrap state");

	// A wrapped index always names a live entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (div_rem < count_q))
		else $error("wrapped index not below the count");

	// A remove is only applied to a list that holds entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == wil_pkg::ST_APPLY) && (kind_q == wil_pkg::KIND_REMOVE))
		|-> (count_q != '0))
		else $error("remove applied to an empty list");

	// An accepted append grows the list by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == wil_pkg::ST_APPLY) && (kind_q == wil_pkg::KIND_APPEND) && !rej_q)
		|=> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("append did not grow the count");

endmodule
